@@ design/slcd_pkg.sv @@
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned FrameLenW = 17;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Shortest frame: head, one length byte, one body byte, checksum, fin.
  localparam logic [FrameLenW-1:0] MinFrameLen = 17'd5;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_SUM  = 3'd3,
    PH_FIN  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_START   = 3'd1,
    ST_BYTE    = 3'd2,
    ST_DONE    = 3'd3,
    ST_BAD_LEN = 3'd4,
    ST_BAD_SUM = 3'd5,
    ST_BAD_FIN = 3'd6,
    ST_TIMEOUT = 3'd7
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD_BYTE   = 2'd0,
    REG_FIN_BYTE    = 2'd1,
    REG_LEN_BYTES   = 2'd2,
    REG_MAX_BODY    = 2'd3
  } reg_idx_t;

  localparam logic [ByteW-1:0] HeadByteRst = 8'd170;
  localparam logic [ByteW-1:0] FinByteRst  = 8'd85;
  localparam logic [1:0]       LenBytesRst = 2'd2;
  localparam logic [LenW-1:0]  MaxBodyRst  = 16'd1024;

endpackage

@@ design/sync_length_checksum_deframer_core.sv @@
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Hunts for length-prefixed frames with an 8-bit sum checksum in a byte
// stream and reports a status for every received item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one item per byte or per
//   receive timeout. Every accepted item yields exactly one result item on
//   the output channel (out_valid/out_ready): a copy of the byte, a status
//   code, and the total frame length when a frame completes.
//   The result of an item is registered and shown in the cycle after it is
//   accepted. Throughput is one item per cycle while results are taken; the
//   frame state update and the 8-bit checksum add sit between the input
//   handshake and the result register.
//   When the receiver stalls, the result register holds its item and
//   in_ready stays low until the result is taken; taking a result and
//   accepting a new item in the same cycle keeps the full rate.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
//   next edge and are meant to be made while the block is idle.
//   A synchronous reset (rst_n low) empties the result register, returns
//   the frame state to hunting and loads the register defaults.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core
  import slcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [ByteW-1:0]     in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ByteW-1:0]     out_data_out,
  output logic [2:0]           out_status,
  output logic [FrameLenW-1:0] out_frame_length,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  logic [ByteW-1:0]     head_byte_r;
  logic [ByteW-1:0]     fin_byte_r;
  logic [1:0]           len_bytes_r;
  logic [LenW-1:0]      max_body_r;

  phase_t               phase_r, phase_nxt;
  logic [LenW-1:0]      body_len_r, body_len_nxt;
  logic [1:0]           len_seen_r, len_seen_nxt;
  logic [LenW-1:0]      body_seen_r, body_seen_nxt;
  logic [ByteW-1:0]     sum_r, sum_nxt;
  logic [FrameLenW-1:0] frame_seen_r, frame_seen_nxt;

  logic                 out_valid_r;
  logic [ByteW-1:0]     dout_r, dout_nxt;
  status_t              status_r, status_nxt;
  logic [FrameLenW-1:0] flen_r, flen_nxt;

  logic                 in_fire;
  logic [1:0]           len_count;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Out-of-range length settings are clamped to one or two bytes.
  always_comb begin
    if (len_bytes_r == 2'd0) begin
      len_count = 2'd1;
    end else if (len_bytes_r == 2'd3) begin
      len_count = 2'd2;
    end else begin
      len_count = len_bytes_r;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    body_len_nxt   = body_len_r;
    len_seen_nxt   = len_seen_r;
    body_seen_nxt  = body_seen_r;
    sum_nxt        = sum_r;
    frame_seen_nxt = frame_seen_r;
    dout_nxt       = in_data_byte;
    status_nxt     = ST_IGNORED;
    flen_nxt       = '0;

    if (in_action) begin
      dout_nxt = '0;
      if (phase_r != PH_HUNT) begin
        status_nxt = ST_TIMEOUT;
        phase_nxt  = PH_HUNT;
      end
    end else begin
      case (phase_r)
        PH_LEN: begin
          body_len_nxt   = {body_len_r[LenW-ByteW-1:0], in_data_byte};
          len_seen_nxt   = len_seen_r + 2'd1;
          sum_nxt        = sum_r + in_data_byte;
          frame_seen_nxt = frame_seen_r + 17'd1;
          status_nxt     = ST_BYTE;
          if (len_seen_nxt >= len_count) begin
            if ((body_len_nxt != '0) && (body_len_nxt <= max_body_r)) begin
              phase_nxt = PH_BODY;
            end else begin
              status_nxt = ST_BAD_LEN;
              phase_nxt  = PH_HUNT;
            end
          end
        end
        PH_BODY: begin
          body_seen_nxt  = body_seen_r + 16'd1;
          sum_nxt        = sum_r + in_data_byte;
          frame_seen_nxt = frame_seen_r + 17'd1;
          status_nxt     = ST_BYTE;
          if (body_seen_nxt >= body_len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          if (in_data_byte == sum_r) begin
            frame_seen_nxt = frame_seen_r + 17'd1;
            status_nxt     = ST_BYTE;
            phase_nxt      = PH_FIN;
          end else begin
            status_nxt = ST_BAD_SUM;
            phase_nxt  = PH_HUNT;
          end
        end
        PH_FIN: begin
          if (in_data_byte == fin_byte_r) begin
            frame_seen_nxt = frame_seen_r + 17'd1;
            status_nxt     = ST_DONE;
            flen_nxt       = frame_seen_nxt;
          end else begin
            status_nxt = ST_BAD_FIN;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (in_data_byte == head_byte_r) begin
            phase_nxt      = PH_LEN;
            body_len_nxt   = '0;
            len_seen_nxt   = '0;
            body_seen_nxt  = '0;
            sum_nxt        = in_data_byte;
            frame_seen_nxt = 17'd1;
            status_nxt     = ST_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= HeadByteRst;
      fin_byte_r  <= FinByteRst;
      len_bytes_r <= LenBytesRst;
      max_body_r  <= MaxBodyRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD_BYTE: head_byte_r <= cfg_wdata[ByteW-1:0];
        REG_FIN_BYTE:  fin_byte_r  <= cfg_wdata[ByteW-1:0];
        REG_LEN_BYTES: len_bytes_r <= cfg_wdata[1:0];
        REG_MAX_BODY:  max_body_r  <= cfg_wdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      body_len_r   <= '0;
      len_seen_r   <= '0;
      body_seen_r  <= '0;
      sum_r        <= '0;
      frame_seen_r <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      body_len_r   <= body_len_nxt;
      len_seen_r   <= len_seen_nxt;
      body_seen_r  <= body_seen_nxt;
      sum_r        <= sum_nxt;
      frame_seen_r <= frame_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dout_r   <= dout_nxt;
      status_r <= status_nxt;
      flen_r   <= flen_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = dout_r;
  assign out_status       = status_r;
  assign out_frame_length = flen_r;

endmodule

@@ design/slcd_checker.sv @@
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level checks of the deframer, bound to the deframer core.
// ----------------------------------------------------------------------------
module slcd_checker
  import slcd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_action,
  input logic [ByteW-1:0]     in_data_byte,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ByteW-1:0]     out_data_out,
  input logic [2:0]           out_status,
  input logic [FrameLenW-1:0] out_frame_length
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_status) && $stable(out_frame_length))
    else $error("result item changed while stalled");

  // A received byte comes back unchanged in the next cycle.
  a_byte_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_action |=>
      out_valid && (out_data_out == $past(in_data_byte)))
    else $error("data byte not echoed");

  // A timeout item reports a zero byte and no frame length.
  a_timeout_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=>
      out_valid && (out_data_out == '0) && (out_frame_length == '0)
      && ((out_status == ST_IGNORED) || (out_status == ST_TIMEOUT)))
    else $error("bad timeout result");

  // Frame length appears only on completion, and a frame has at least five bytes.
  a_frame_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_DONE) ? (out_frame_length >= MinFrameLen)
                                           : (out_frame_length == '0)))
    else $error("frame length inconsistent with status");

endmodule

bind sync_length_checksum_deframer_core slcd_checker u_slcd_checker (.*);
